// File: hw/rtl/rgba_color_matrix_filter_macros.svh
// assertion macros shared by the rgba color matrix filter rtl
`ifndef RGBA_COLOR_MATRIX_FILTER_MACROS_SVH
`define RGBA_COLOR_MATRIX_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while in reset
`define RCMF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define RCMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RCMF_ASSERT_IMPLY(lbl, ante, cons, msg)

`define RCMF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hw/rtl/rcmf_pkg.sv
// shared types and constants of the rgba color matrix filter
package rcmf_pkg;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int ROW_W      = 4 * COEF_W;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // signed product of an 8-bit pixel and a 16-bit coefficient
  localparam int PROD_W  = PIX_W + COEF_W + 1;
  // four products summed
  localparam int SUM_W   = PROD_W + 1;
  // unsigned alpha times gain
  localparam int APROD_W = PIX_W + GAIN_W;

  localparam int COEF_FRAC_BITS_DEF = 12;

  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RED_ROW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_ROW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_ROW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_GAIN = 3'd3;

  // identity filter after reset
  localparam logic [ROW_W-1:0]  RED_ROW_RST    = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0]  GREEN_ROW_RST  = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0]  BLUE_ROW_RST   = 64'h0000_1000_0000_0000;
  localparam logic [GAIN_W-1:0] ALPHA_GAIN_RST = 16'h1000;

  typedef struct packed {
    logic [ROW_W-1:0]  red_row;
    logic [ROW_W-1:0]  green_row;
    logic [ROW_W-1:0]  blue_row;
    logic [GAIN_W-1:0] alpha_gain;
  } cfg_t;

  // per-stage enables of the pixel pipeline
  typedef struct packed {
    logic mul;
    logic sum;
    logic sat;
  } stage_en_t;

endpackage

// File: hw/rtl/rgba_color_matrix_filter.sv
// top level of the rgba color matrix filter
// a pixel moves from the start edge through the product, sum and result registers to the out_valid strobe
// throughput: one pixel per clock, start may stay high every cycle
// busy stays low; the pipeline never stalls since results cannot be held off
// rst_n (synchronous) clears the stage valids and loads the identity filter
// cfg_ready is always high; writes are registered
`include "rgba_color_matrix_filter_macros.svh"

module rgba_color_matrix_filter
  import rcmf_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  // pixel input, one transaction per start while not busy
  input  logic                  start,
  output logic                  busy,
  input  logic [PIX_W-1:0]      in_red,
  input  logic [PIX_W-1:0]      in_green,
  input  logic [PIX_W-1:0]      in_blue,
  input  logic [PIX_W-1:0]      in_alpha,

  // filtered pixel, valid for a single cycle
  output logic                  out_valid,
  output logic [PIX_W-1:0]      out_red,
  output logic [PIX_W-1:0]      out_green,
  output logic [PIX_W-1:0]      out_blue,
  output logic [PIX_W-1:0]      out_alpha,

  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic      accept;
  logic      mul_vld_r;
  logic      sum_vld_r;
  logic      out_vld_r;
  stage_en_t en;
  cfg_t      cfg;

  // no backpressure anywhere, so a new pixel is taken every cycle
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // valid bits ride alongside the lane data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      sum_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= accept;
      sum_vld_r <= mul_vld_r;
      out_vld_r <= sum_vld_r;
    end
  end

  // stage enables: products load on accept, sums and results follow
  assign en.mul = accept;
  assign en.sum = mul_vld_r;
  assign en.sat = sum_vld_r;

  rcmf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // one lane per color output, each with its own row of coefficients
  rcmf_color_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_red (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .red    (in_red),
    .green  (in_green),
    .blue   (in_blue),
    .row    (cfg.red_row),
    .result (out_red)
  );

  rcmf_color_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_green (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .red    (in_red),
    .green  (in_green),
    .blue   (in_blue),
    .row    (cfg.green_row),
    .result (out_green)
  );

  rcmf_color_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_blue (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .red    (in_red),
    .green  (in_green),
    .blue   (in_blue),
    .row    (cfg.blue_row),
    .result (out_blue)
  );

  // alpha only scales by its own gain
  rcmf_alpha_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_alpha (
    .clk    (clk),
    .en     (en),
    .alpha  (in_alpha),
    .gain   (cfg.alpha_gain),
    .result (out_alpha)
  );

  assign out_valid = out_vld_r;

  // every result strobe traces back to a taken transaction through the product and sum valids
  `RCMF_ASSERT_IMPLY(a_out_from_accept, out_vld_r, $past(accept, 3), "result strobe without matching input transaction")
  // a taken pixel moves to the sum stage
  `RCMF_ASSERT_NEXT(a_mul_to_sum, mul_vld_r, sum_vld_r, "valid lost between product and sum stage")
  // a summed pixel always produces a result strobe
  `RCMF_ASSERT_NEXT(a_sum_to_out, sum_vld_r, out_vld_r, "valid lost between sum and result stage")

endmodule

// File: hw/rtl/rcmf_cfg_regs.sv
// configuration registers of the rgba color matrix filter
`include "rgba_color_matrix_filter_macros.svh"

module rcmf_cfg_regs
  import rcmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_RED_ROW:    cfg_nxt.red_row    = wr_data[ROW_W-1:0];
        REG_GREEN_ROW:  cfg_nxt.green_row  = wr_data[ROW_W-1:0];
        REG_BLUE_ROW:   cfg_nxt.blue_row   = wr_data[ROW_W-1:0];
        REG_ALPHA_GAIN: cfg_nxt.alpha_gain = wr_data[GAIN_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_row    <= RED_ROW_RST;
      cfg_r.green_row  <= GREEN_ROW_RST;
      cfg_r.blue_row   <= BLUE_ROW_RST;
      cfg_r.alpha_gain <= ALPHA_GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

  // writes to unknown indexes leave every register alone
  `RCMF_ASSERT_NEXT(a_cfg_unknown_idx_ignored, wr_en && (wr_index != REG_RED_ROW) && (wr_index != REG_GREEN_ROW) && (wr_index != REG_BLUE_ROW) && (wr_index != REG_ALPHA_GAIN), $stable(cfg_r), "write to unknown register index changed state")

endmodule

// File: hw/rtl/rcmf_color_lane.sv
// one color output: multiply, sum, saturate over three register stages
`include "rgba_color_matrix_filter_macros.svh"

module rcmf_color_lane
  import rcmf_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  stage_en_t        en,
  input  logic [PIX_W-1:0] red,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] blue,
  input  logic [ROW_W-1:0] row,
  output logic [PIX_W-1:0] result
);

  logic signed [PROD_W-1:0] pix_ext [4];
  logic signed [PROD_W-1:0] coef_ext [4];
  logic signed [PROD_W-1:0] prod_nxt [4];
  logic signed [PROD_W-1:0] prod_r [4];
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [SUM_W-1:0]  sum_r;
  logic [PIX_W-1:0]         sat_nxt;
  logic [PIX_W-1:0]         sat_r;

  // slot order: red, green, blue, offset (scaled by full-scale pixel)
  always_comb begin
    pix_ext[0] = $signed({{(PROD_W-PIX_W){1'b0}}, red});
    pix_ext[1] = $signed({{(PROD_W-PIX_W){1'b0}}, green});
    pix_ext[2] = $signed({{(PROD_W-PIX_W){1'b0}}, blue});
    pix_ext[3] = $signed({{(PROD_W-PIX_W){1'b0}}, PIX_MAX});
    for (int k = 0; k < 4; k++) begin
      coef_ext[k] = $signed({{(PROD_W-COEF_W){row[COEF_W*k+COEF_W-1]}},
                             row[COEF_W*k +: COEF_W]});
      prod_nxt[k] = pix_ext[k] * coef_ext[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod_r <= prod_nxt;
    end
  end

  assign sum_nxt = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1])
                 + SUM_W'(prod_r[2]) + SUM_W'(prod_r[3]);

  always_ff @(posedge clk) begin
    if (en.sum) begin
      sum_r <= sum_nxt;
    end
  end

  // floor by the fraction width, clamp to 0..255
  always_comb begin
    priority if (sum_r[SUM_W-1]) begin
      sat_nxt = '0;
    end else if (|sum_r[SUM_W-2:COEF_FRAC_BITS+PIX_W]) begin
      sat_nxt = PIX_MAX;
    end else begin
      sat_nxt = sum_r[COEF_FRAC_BITS +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en.sat) begin
      sat_r <= sat_nxt;
    end
  end

  assign result = sat_r;

  // a negative sum must come out as zero
  `RCMF_ASSERT_NEXT(a_lane_neg_clamps_zero, en.sat && sum_r[SUM_W-1], sat_r == '0, "negative sum not clamped to zero")

endmodule

// File: hw/rtl/rcmf_alpha_lane.sv
// alpha output: gain multiply, overflow check, saturated result register
module rcmf_alpha_lane
  import rcmf_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  stage_en_t         en,
  input  logic [PIX_W-1:0]  alpha,
  input  logic [GAIN_W-1:0] gain,
  output logic [PIX_W-1:0]  result
);

  logic [APROD_W-1:0] prod_nxt;
  logic [APROD_W-1:0] prod_r;
  logic               ovf_r;
  logic [PIX_W-1:0]   quo_r;
  logic [PIX_W-1:0]   sat_r;

  assign prod_nxt = APROD_W'(alpha) * APROD_W'(gain);

  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod_r <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      ovf_r <= |prod_r[APROD_W-1:COEF_FRAC_BITS+PIX_W];
      quo_r <= prod_r[COEF_FRAC_BITS +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en.sat) begin
      sat_r <= ovf_r ? PIX_MAX : quo_r;
    end
  end

  assign result = sat_r;

endmodule
